[rtl/sccc_pkg.sv]
// ----------------------------------------------------------------------------
// Snooping cache controller package
// Line states, bus signal codes, operation codes and geometry defaults.
// ----------------------------------------------------------------------------
package sccc_pkg;

  localparam int unsigned DefSets      = 256;
  localparam int unsigned DefWays      = 4;
  localparam int unsigned DefLineBytes = 64;
  localparam int unsigned DefAddrBits  = 32;

  localparam int unsigned StampW = 32;

  typedef enum logic [2:0] {
    ST_INV = 3'd0,
    ST_SHR = 3'd1,
    ST_MOD = 3'd2,
    ST_EXC = 3'd3,
    ST_SC  = 3'd4,
    ST_SM  = 3'd5
  } line_state_t;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_RD   = 2'd1;
  localparam logic [1:0] SIG_RDX  = 2'd2;
  localparam logic [1:0] SIG_UPD  = 2'd3;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_SNOOP = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOOKUP,
    PH_OUT
  } phase_t;

  function automatic int unsigned flog2(input int unsigned v);
    int unsigned n;
    int unsigned x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

[rtl/snooping_coherent_cache_controller.sv]
// ----------------------------------------------------------------------------
// Snooping coherent cache controller
// Set-associative tag store with LRU stamps and MSI or Dragon line states.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in      | in        | in_valid/in_stall| opcode, address, other_copy, snoop_signal
//  out     | out       | out_valid/out_stall | hit_or_present .. intervention
//  cfg     | in        | cfg_we           | cfg_data (protocol_mode)
//
// Each beat has its set read from the memories as it is accepted, is decided
// and written back in the lookup phase, and then passes an output turnaround
// phase before the next beat can be taken. The result is registered at the end
// of the lookup phase and waits in the output register; a new beat is taken
// once that register is free or being emptied.
// After reset a clearing pass marks every line invalid; no beat is accepted
// until it ends. Tags and stamps are not cleared.
module snooping_coherent_cache_controller
  import sccc_pkg::*;
#(
  parameter int unsigned SETS       = DefSets,
  parameter int unsigned WAYS       = DefWays,
  parameter int unsigned LINE_BYTES = DefLineBytes,
  parameter int unsigned ADDR_BITS  = DefAddrBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] address,
  input  logic        other_copy,
  input  logic [1:0]  snoop_signal,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit_or_present,
  output logic [1:0]  bus_request,
  output logic        victim_writeback,
  output logic        flush,
  output logic        invalidated,
  output logic        intervention
);

  localparam int unsigned OffB  = flog2(LINE_BYTES);
  localparam int unsigned IdxB  = flog2(SETS);
  localparam int unsigned IdxW  = (IdxB == 0) ? 1 : IdxB;
  localparam int unsigned ABits = (ADDR_BITS > 32) ? 32 : ADDR_BITS;
  localparam int unsigned TagW  = (ABits > OffB + IdxB) ? ABits - OffB - IdxB : 1;
  localparam int unsigned WayW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned Depth = 1 << IdxB;

  typedef logic [TagW-1:0]   tag_t;
  typedef logic [StampW-1:0] stamp_t;

  // One memory row holds a whole set: all ways side by side.
  logic [WAYS*TagW-1:0]   tag_mem   [Depth];
  logic [WAYS*3-1:0]      state_mem [Depth];
  logic [WAYS*StampW-1:0] stamp_mem [Depth];

  logic [WAYS*TagW-1:0]   tag_rd;
  logic [WAYS*3-1:0]      state_rd;
  logic [WAYS*StampW-1:0] stamp_rd;

  phase_t phase, phase_next;
  logic   mode;
  stamp_t access_clock;
  logic   clearing;
  logic [IdxW:0] clr_cnt;

  logic [1:0]     op_q;
  logic [IdxW-1:0] set_q;
  tag_t           tag_q;
  logic           copy_q;
  logic [1:0]     sig_q;

  logic [31:0]     addr_cut;
  logic [IdxW-1:0] set_in;
  tag_t            tag_in;

  logic accept;
  logic out_take;

  assign addr_cut = (ABits >= 32) ? address : (address & ((32'd1 << ABits) - 32'd1));
  assign set_in   = (IdxB == 0) ? '0 : IdxW'(addr_cut >> OffB);
  assign tag_in   = tag_t'(addr_cut >> (OffB + IdxB));

  assign out_take = out_valid && !out_stall;
  assign in_stall = clearing || (phase != PH_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // Next-state logic.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE:   if (accept) phase_next = PH_LOOKUP;
      PH_LOOKUP: phase_next = PH_OUT;
      PH_OUT:    phase_next = PH_IDLE;
      default:   phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_we) begin
      mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= opcode;
      set_q  <= set_in;
      tag_q  <= tag_in;
      copy_q <= other_copy;
      sig_q  <= snoop_signal;
    end
  end

  // Decision logic on the read set.
  logic              hit;
  logic [WayW-1:0]   hit_way;
  logic              inv_found;
  logic [WayW-1:0]   inv_way;
  logic [WayW-1:0]   lru_way;
  stamp_t            best;
  logic [WayW-1:0]   way;
  line_state_t       st;
  line_state_t       st_new;
  stamp_t            clk_new;
  logic              is_proc;
  logic              do_write;
  logic              r_hit, r_wb, r_fl, r_inv, r_itv;
  logic [1:0]        r_bus;
  logic              upd_tag, upd_stamp;

  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    inv_found = 1'b0;
    inv_way = '0;
    lru_way = WayW'(WAYS - 1);
    best = '1;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (state_rd[w*3 +: 3] != ST_INV && tag_rd[w*TagW +: TagW] == tag_q) begin
        hit = 1'b1;
        hit_way = WayW'(w);
      end
      if (state_rd[w*3 +: 3] == ST_INV) begin
        inv_found = 1'b1;
        inv_way = WayW'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (stamp_rd[w*StampW +: StampW] <= best) begin
        best = stamp_rd[w*StampW +: StampW];
        lru_way = WayW'(w);
      end
    end
  end

  always_comb begin
    is_proc   = (op_q == OP_READ) || (op_q == OP_WRITE);
    clk_new   = access_clock + stamp_t'(1);
    way       = hit ? hit_way : (inv_found ? inv_way : lru_way);
    st        = line_state_t'(state_rd[way*3 +: 3]);
    st_new    = st;
    r_hit     = 1'b0;
    r_bus     = SIG_NONE;
    r_wb      = 1'b0;
    r_fl      = 1'b0;
    r_inv     = 1'b0;
    r_itv     = 1'b0;
    upd_tag   = 1'b0;
    upd_stamp = 1'b0;
    if (is_proc) begin
      upd_stamp = 1'b1;
      if (hit) begin
        r_hit = 1'b1;
        if (op_q == OP_WRITE) begin
          if (!mode) begin
            st_new = ST_MOD;
          end else if (st == ST_SM) begin
            if (!copy_q) st_new = ST_MOD;
            r_bus = SIG_UPD;
          end else if (st == ST_SC) begin
            st_new = copy_q ? ST_SM : ST_MOD;
            r_bus = SIG_UPD;
          end else if (st == ST_EXC) begin
            st_new = ST_MOD;
          end
        end
      end else begin
        upd_tag = 1'b1;
        r_wb = (st == ST_MOD) || (st == ST_SM);
        if (op_q == OP_WRITE) begin
          if (!mode) begin
            r_bus = SIG_RDX;
            st_new = ST_MOD;
          end else if (copy_q) begin
            r_bus = SIG_UPD;
            st_new = ST_SM;
          end else begin
            r_bus = SIG_RD;
            st_new = ST_MOD;
          end
        end else begin
          r_bus = SIG_RD;
          st_new = !mode ? ST_SHR : (copy_q ? ST_SC : ST_EXC);
        end
      end
    end else if (op_q == OP_SNOOP && hit) begin
      r_hit = 1'b1;
      if (!mode) begin
        if (sig_q == SIG_RD || sig_q == SIG_RDX) begin
          if (st == ST_MOD) begin
            st_new = ST_INV;
            r_inv = 1'b1;
            r_fl = 1'b1;
          end else if (st == ST_SHR) begin
            st_new = ST_INV;
            r_inv = 1'b1;
          end
        end
      end else if (st == ST_MOD) begin
        if (sig_q == SIG_RD) begin
          st_new = ST_SM;
          r_fl = 1'b1;
          r_itv = 1'b1;
        end
      end else if (st == ST_SM) begin
        if (sig_q == SIG_RD) r_fl = 1'b1;
        else if (sig_q == SIG_UPD) st_new = ST_SC;
      end else if (st == ST_EXC) begin
        if (sig_q == SIG_RD) begin
          st_new = ST_SC;
          r_itv = 1'b1;
        end
      end
    end
    do_write = (phase == PH_LOOKUP);
  end

  // Clearing pass over the state memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == (IdxW+1)'(Depth - 1)) clearing <= 1'b0;
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  logic [IdxW-1:0] rd_addr;
  assign rd_addr = set_in;

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_rd   <= tag_mem[rd_addr];
      state_rd <= state_mem[rd_addr];
      stamp_rd <= stamp_mem[rd_addr];
    end
  end

  logic [WAYS*TagW-1:0]   tag_wr;
  logic [WAYS*3-1:0]      state_wr;
  logic [WAYS*StampW-1:0] stamp_wr;

  always_comb begin
    tag_wr   = tag_rd;
    state_wr = state_rd;
    stamp_wr = stamp_rd;
    state_wr[way*3 +: 3] = st_new;
    if (upd_tag) tag_wr[way*TagW +: TagW] = tag_q;
    if (upd_stamp) stamp_wr[way*StampW +: StampW] = clk_new;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      state_mem[clr_cnt[IdxW-1:0]] <= '0;
    end else if (do_write) begin
      state_mem[set_q] <= state_wr;
      tag_mem[set_q]   <= tag_wr;
      stamp_mem[set_q] <= stamp_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock <= '0;
    end else if (do_write && is_proc) begin
      access_clock <= clk_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_write) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      hit_or_present   <= r_hit;
      bus_request      <= r_bus;
      victim_writeback <= r_wb;
      flush            <= r_fl;
      invalidated      <= r_inv;
      intervention     <= r_itv;
    end
  end

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept) else $error("beat accepted during clearing pass");
  a_lookup_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> phase == PH_LOOKUP) else $error("lookup phase missed");
  a_result_after: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LOOKUP |=> out_valid) else $error("result not registered");
  a_snoop_no_bus: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (flush || invalidated || intervention)) |-> bus_request == SIG_NONE)
    else $error("snoop result carries a bus request");

endmodule
